FILE: rtl/set_assoc_cache_controller_defines.svh
// Assertion macros for the checker module.
`ifndef SET_ASSOC_CACHE_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_CONTROLLER_DEFINES_SVH

// same-cycle implication, off during reset
`define SACC_AST_COMB(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SACC_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset as well
`define SACC_AST_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sacc_pkg.sv
package sacc_pkg;

  localparam int ADDR_BITS  = 32;
  localparam int STAMP_W    = 32;
  localparam int BYTES_W    = 7;
  localparam int WAY_OUT_W  = 3;
  localparam int WAY_IDX_W  = 4;
  localparam int CYC_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_THROUGH  = 2'd0,
    CFG_WRITE_ALLOCATE = 2'd1,
    CFG_BUS_LATENCY    = 2'd2,
    CFG_HIT_LATENCY    = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EVICT = 5'b10000
  } state_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 free_found;
    logic [WAY_IDX_W-1:0] free_way;
  } lookup_t;

  function automatic int flog2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

FILE: rtl/sacc_ram.sv
module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/sacc_lookup.sv
module sacc_lookup #(
  parameter int WAYS  = 8,
  parameter int TAG_W = 20
) (
  input  logic [WAYS-1:0][TAG_W+sacc_pkg::STAMP_W+1:0] row,
  input  logic [TAG_W-1:0]                             tag,
  output sacc_pkg::lookup_t                            lk
);

  localparam int IW    = sacc_pkg::WAY_IDX_W;
  localparam int T_LSB = sacc_pkg::STAMP_W;
  localparam int D_BIT = sacc_pkg::STAMP_W + TAG_W;
  localparam int V_BIT = D_BIT + 1;

  // descending scan leaves the lowest matching way in place
  always_comb begin
    lk = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (row[i][V_BIT] && row[i][D_BIT-1:T_LSB] == tag) begin
        lk.hit     = 1'b1;
        lk.hit_way = IW'(i);
      end
      if (!row[i][V_BIT]) begin
        lk.free_found = 1'b1;
        lk.free_way   = IW'(i);
      end
    end
  end

endmodule

FILE: rtl/set_assoc_cache_controller.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready   | address, operation, byte_count
// out_    | output    | out_valid / out_ready | hit, way, writeback, fetch, forward, cycles
// cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// Hit, fill into a free way and forward-only writes first read the set row from the tag
// RAM, then compare and write the row back.
// A miss into a full set adds an LRU scan of one way per cycle.
// After reset a clearing pass writes every one of the 2**floor(log2(SETS)) set rows
// (64 at default), with in_ready low. A waiting result holds the finishing step.
module set_assoc_cache_controller #(
  parameter int SETS        = 64,
  parameter int WAYS        = 8,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sacc_pkg::ADDR_BITS-1:0]     in_address,
  input  logic                               in_operation,
  input  logic [sacc_pkg::BYTES_W-1:0]       in_byte_count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [sacc_pkg::WAY_OUT_W-1:0]     out_way,
  output logic                               out_writeback_valid,
  output logic [sacc_pkg::ADDR_BITS-1:0]     out_writeback_address,
  output logic                               out_fetch_valid,
  output logic [sacc_pkg::ADDR_BITS-1:0]     out_fetch_address,
  output logic                               out_forward_valid,
  output logic [sacc_pkg::ADDR_BITS-1:0]     out_forward_address,
  output logic [sacc_pkg::BYTES_W-1:0]       out_forward_bytes,
  output logic [sacc_pkg::CYC_W-1:0]         out_access_cycles,
  input  logic                               cfg_we,
  input  logic [sacc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sacc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AB      = sacc_pkg::ADDR_BITS;
  localparam int SW      = sacc_pkg::STAMP_W;
  localparam int OFF_W   = sacc_pkg::flog2(BLOCK_BYTES);
  localparam int SET_W   = sacc_pkg::flog2(SETS);
  localparam int NSETS   = 1 << SET_W;
  localparam int SET_IW  = (SET_W > 0) ? SET_W : 1;
  localparam int AW_EFF  = (ADDR_WIDTH < AB) ? ADDR_WIDTH : AB;
  localparam int TAG_LSB = OFF_W + SET_W;
  localparam int TAG_RAW = AW_EFF - TAG_LSB;
  localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W   = TAG_W + SW + 2;
  localparam int ROW_W   = WAYS * ENT_W;
  localparam int D_BIT   = SW + TAG_W;
  localparam int V_BIT   = D_BIT + 1;
  localparam int CW      = sacc_pkg::CYC_W;

  localparam logic [AB-1:0] AMASK    = (AW_EFF >= AB) ? {AB{1'b1}}
                                                      : AB'((64'd1 << AW_EFF) - 64'd1);
  localparam logic [AB-1:0] SET_MASK = AB'((64'd1 << SET_W) - 64'd1);
  localparam logic [AB-1:0] OFF_MASK = AB'((64'd1 << OFF_W) - 64'd1);

  sacc_pkg::state_t state_r, state_nxt;

  logic [SET_IW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0]           clock_r, clock_nxt;
  logic                    wt_r, wt_nxt;
  logic                    wa_r, wa_nxt;
  logic [7:0]              bus_r, bus_nxt;
  logic [7:0]              hitl_r, hitl_nxt;

  logic [AB-1:0]           addr_r;
  logic                    op_r;
  logic [sacc_pkg::BYTES_W-1:0] bytes_r;
  logic [WAY_W-1:0]        scan_r, scan_nxt;
  logic [WAY_W-1:0]        victim_r, victim_nxt;
  logic [SW-1:0]           best_r, best_nxt;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [sacc_pkg::WAY_OUT_W-1:0] out_way_r;
  logic                    out_wb_v_r;
  logic [AB-1:0]           out_wb_a_r;
  logic                    out_f_v_r;
  logic [AB-1:0]           out_f_a_r;
  logic                    out_fw_v_r;
  logic [AB-1:0]           out_fw_a_r;
  logic [sacc_pkg::BYTES_W-1:0] out_fw_b_r;
  logic [CW-1:0]           out_cyc_r;

  logic                    accept;
  logic                    out_free;
  logic [AB-1:0]           in_addr_m;
  logic [SET_IW-1:0]       in_set;
  logic [SET_IW-1:0]       set_idx;
  logic [TAG_W-1:0]        tag_w;
  logic [AB-1:0]           block_addr;
  logic                    is_write;
  logic                    no_alloc;
  logic                    need_evict;
  logic                    finish;

  logic [WAYS-1:0][ENT_W-1:0] rd_row;
  logic [WAYS-1:0][ENT_W-1:0] new_row;
  logic [ROW_W-1:0]        rd_data;
  logic                    ram_we;
  logic [SET_IW-1:0]       ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  sacc_pkg::lookup_t       lk;

  logic [WAY_W-1:0]        tgt_way;
  logic [SW-1:0]           scan_stamp;
  logic [TAG_W-1:0]        vic_tag;
  logic [63:0]             wb_wide;
  logic                    row_wr;
  logic                    res_hit;
  logic                    res_wb_v;
  logic [AB-1:0]           res_wb_a;
  logic                    res_f_v;
  logic [AB-1:0]           res_f_a;
  logic                    res_fw_v;
  logic [AB-1:0]           res_fw_a;
  logic [sacc_pkg::BYTES_W-1:0] res_fw_b;

  assign in_ready  = (state_r == sacc_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_addr_m = in_address & AMASK;
  assign in_set    = SET_IW'((in_addr_m >> OFF_W) & SET_MASK);
  assign set_idx   = SET_IW'((addr_r >> OFF_W) & SET_MASK);
  assign tag_w     = TAG_W'(addr_r >> TAG_LSB);
  assign block_addr = addr_r & ~OFF_MASK;
  assign is_write  = op_r;
  assign rd_row    = rd_data;

  sacc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_set),
    .rdata (rd_data)
  );

  sacc_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_lookup (
    .row (rd_row),
    .tag (tag_w),
    .lk  (lk)
  );

  assign no_alloc   = is_write && !wa_r;
  assign need_evict = !lk.hit && !no_alloc && !lk.free_found;
  assign finish     = ((state_r == sacc_pkg::S_LOOK) && out_free && !need_evict) ||
                      ((state_r == sacc_pkg::S_EVICT) && out_free);

  assign ram_we    = (state_r == sacc_pkg::S_CLEAR) || (finish && row_wr);
  assign ram_waddr = (state_r == sacc_pkg::S_CLEAR) ? clr_cnt_r : set_idx;
  assign ram_wdata = (state_r == sacc_pkg::S_CLEAR) ? '0 : new_row;

  assign scan_stamp = rd_row[scan_r][SW-1:0];
  assign vic_tag    = rd_row[victim_r][D_BIT-1:SW];
  assign wb_wide    = (64'(vic_tag) << TAG_LSB) | (64'(set_idx) << OFF_W);

  // result and updated set row for the finishing step
  always_comb begin
    new_row  = rd_row;
    row_wr   = 1'b0;
    res_hit  = 1'b0;
    res_wb_v = 1'b0;
    res_wb_a = '0;
    res_f_v  = 1'b0;
    res_f_a  = '0;
    res_fw_v = 1'b0;
    res_fw_a = '0;
    res_fw_b = '0;
    tgt_way  = '0;
    if (state_r == sacc_pkg::S_EVICT || (!lk.hit && !no_alloc)) begin
      tgt_way = (state_r == sacc_pkg::S_EVICT) ? victim_r : lk.free_way[WAY_W-1:0];
      row_wr  = 1'b1;
      new_row[tgt_way] = {1'b1, is_write && !wt_r, tag_w, clock_r};
      res_f_v = 1'b1;
      res_f_a = block_addr;
      if (state_r == sacc_pkg::S_EVICT && !wt_r && rd_row[victim_r][D_BIT]) begin
        res_wb_v = 1'b1;
        res_wb_a = wb_wide[AB-1:0];
      end
    end else if (lk.hit) begin
      tgt_way = lk.hit_way[WAY_W-1:0];
      row_wr  = 1'b1;
      res_hit = 1'b1;
      new_row[tgt_way] = {1'b1, rd_row[tgt_way][D_BIT] || (is_write && !wt_r),
                          tag_w, clock_r};
    end
    if (is_write && (wt_r || (!lk.hit && no_alloc && state_r != sacc_pkg::S_EVICT))) begin
      res_fw_v = 1'b1;
      res_fw_a = addr_r;
      res_fw_b = bytes_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    clock_nxt   = clock_r;
    scan_nxt    = scan_r;
    victim_nxt  = victim_r;
    best_nxt    = best_r;
    unique case (state_r)
      sacc_pkg::S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_IW'(NSETS - 1)) begin
          state_nxt = sacc_pkg::S_IDLE;
        end
      end
      sacc_pkg::S_IDLE: begin
        if (accept) begin
          clock_nxt = clock_r + 1'b1;
          state_nxt = sacc_pkg::S_LOOK;
        end
      end
      sacc_pkg::S_LOOK: begin
        if (need_evict) begin
          victim_nxt = '0;
          best_nxt   = rd_row[0][SW-1:0];
          scan_nxt   = WAY_W'(1);
          state_nxt  = (WAYS == 1) ? sacc_pkg::S_EVICT : sacc_pkg::S_SCAN;
        end else if (out_free) begin
          state_nxt = sacc_pkg::S_IDLE;
        end
      end
      sacc_pkg::S_SCAN: begin
        // strict less-than keeps the lowest way on ties
        if (scan_stamp < best_r) begin
          best_nxt   = scan_stamp;
          victim_nxt = scan_r;
        end
        scan_nxt = scan_r + 1'b1;
        if (scan_r == WAY_W'(WAYS - 1)) begin
          state_nxt = sacc_pkg::S_EVICT;
        end
      end
      sacc_pkg::S_EVICT: begin
        if (out_free) begin
          state_nxt = sacc_pkg::S_IDLE;
        end
      end
      default: state_nxt = sacc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    wt_nxt   = wt_r;
    wa_nxt   = wa_r;
    bus_nxt  = bus_r;
    hitl_nxt = hitl_r;
    if (cfg_we) begin
      unique case (sacc_pkg::cfg_idx_t'(cfg_index))
        sacc_pkg::CFG_WRITE_THROUGH:  wt_nxt   = cfg_wdata[0];
        sacc_pkg::CFG_WRITE_ALLOCATE: wa_nxt   = cfg_wdata[0];
        sacc_pkg::CFG_BUS_LATENCY:    bus_nxt  = cfg_wdata;
        sacc_pkg::CFG_HIT_LATENCY:    hitl_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sacc_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
      wt_r        <= 1'b0;
      wa_r        <= 1'b1;
      bus_r       <= 8'd1;
      hitl_r      <= 8'd1;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      clock_r   <= clock_nxt;
      wt_r      <= wt_nxt;
      wa_r      <= wa_nxt;
      bus_r     <= bus_nxt;
      hitl_r    <= hitl_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r  <= in_addr_m;
      op_r    <= in_operation;
      bytes_r <= in_byte_count;
    end
    scan_r   <= scan_nxt;
    victim_r <= victim_nxt;
    best_r   <= best_nxt;
    if (finish) begin
      out_hit_r  <= res_hit;
      out_way_r  <= sacc_pkg::WAY_OUT_W'(tgt_way);
      out_wb_v_r <= res_wb_v;
      out_wb_a_r <= res_wb_a;
      out_f_v_r  <= res_f_v;
      out_f_a_r  <= res_f_a;
      out_fw_v_r <= res_fw_v;
      out_fw_a_r <= res_fw_a;
      out_fw_b_r <= res_fw_b;
      out_cyc_r  <= CW'(bus_r) + CW'(hitl_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hit               = out_hit_r;
  assign out_way               = out_way_r;
  assign out_writeback_valid   = out_wb_v_r;
  assign out_writeback_address = out_wb_a_r;
  assign out_fetch_valid       = out_f_v_r;
  assign out_fetch_address     = out_f_a_r;
  assign out_forward_valid     = out_fw_v_r;
  assign out_forward_address   = out_fw_a_r;
  assign out_forward_bytes     = out_fw_b_r;
  assign out_access_cycles     = out_cyc_r;

endmodule

FILE: rtl/sacc_checker.sv
`include "set_assoc_cache_controller_defines.svh"

module sacc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_hit,
  input logic [sacc_pkg::WAY_OUT_W-1:0]  out_way,
  input logic                            out_writeback_valid,
  input logic                            out_fetch_valid,
  input logic [sacc_pkg::ADDR_BITS-1:0]  out_fetch_address
);

  `SACC_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_way) && $stable(out_fetch_address), "stalled item changed")
  `SACC_AST_COMB(a_hit_no_fill, out_valid && out_hit, !out_fetch_valid && !out_writeback_valid, "hit with fill or writeback")
  `SACC_AST_COMB(a_wb_needs_fill, out_valid && out_writeback_valid, out_fetch_valid && !out_hit, "writeback without fill")
  `SACC_AST_RESET(a_reset_quiet, !rst_n, !in_ready && !out_valid, "ready or valid right after reset")
  `SACC_AST_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "item taken while one is in flight")

endmodule

bind set_assoc_cache_controller sacc_checker u_sacc_checker (.*);
